@@ src/tpfe_pkg.sv @@
// shared types and constants of the trajectory pair feature extractor
package tpfe_pkg;

	localparam int CoordBits = 12;
	localparam int FracBits = 4;
	localparam int MaxPoints = 64;
	localparam int CntBits = $clog2(MaxPoints + 1);
	localparam int DiffBits = CoordBits + 1;
	localparam int DeltaBits = CoordBits + 1;
	localparam int MisBits = CoordBits + 3;
	localparam int LenBits = 23;
	localparam int RadBits = 2 * DeltaBits + 2 * FracBits;
	localparam int RootBits = (RadBits + 1) / 2;
	localparam int SqBits = 2 * MisBits;

	// word passed from front to back through the queue
	typedef struct packed {
		logic [CoordBits-1:0] xa;
		logic [CoordBits-1:0] ya;
		logic [CoordBits-1:0] xb;
		logic [CoordBits-1:0] yb;
		logic                 last;
	} tpfe_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PX, ST_PY, ST_VX, ST_VY, ST_AX, ST_AY, ST_LA, ST_LB,
		ST_SQRT, ST_ADDL, ST_DIV, ST_OUT
	} tpfe_state_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
		input int w);
		logic [64:0] s;
		logic [63:0] lim;
		s = {1'b0, a} + {1'b0, b};
		lim = (64'd1 << w) - 64'd1;
		sat_add = (s > {1'b0, lim}) ? lim : s[63:0];
	endfunction

endpackage

@@ src/tpfe_queue.sv @@
// two-entry word queue between front and back
module tpfe_queue import tpfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  tpfe_word_t wr_word,
	output logic       rd_valid,
	input  logic       rd_ready,
	output tpfe_word_t rd_word
);
	tpfe_word_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_word = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_word;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("full queue lost a word");
	a_empty_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !push) |=> !rd_valid)
		else $error("empty queue shows a word");
`endif
endmodule

@@ src/tpfe_back.sv @@
// sequencer: accumulation, square roots, ratio divide and result register
module tpfe_back import tpfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tpfe_word_t       in_word,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [16:0]      length_ratio,
	output logic [29:0]      pos_x_sum,
	output logic [29:0]      pos_y_sum,
	output logic [31:0]      vel_x_sum,
	output logic [31:0]      vel_y_sum,
	output logic [33:0]      acc_x_sum,
	output logic [33:0]      acc_y_sum,
	output logic [23:0]      first_x_sq,
	output logic [23:0]      first_y_sq,
	output logic [23:0]      end_x_sq,
	output logic [23:0]      end_y_sq,
	output logic             too_short
);
	tpfe_state_t state_q, state_d;
	tpfe_word_t w_q;
	logic signed [DeltaBits-1:0] pax_q, pay_q, pbx_q, pby_q;
	logic signed [DeltaBits-1:0] dax_q, day_q, dbx_q, dby_q;
	logic [SqBits-1:0] fx_q, fy_q, ex_q, ey_q;
	logic [29:0] posx_q, posy_q;
	logic [31:0] velx_q, vely_q;
	logic [33:0] accx_q, accy_q;
	logic [LenBits-1:0] la_q, lb_q;
	logic [CntBits-1:0] n_q;
	logic sel_b_q;
	// square root unit
	logic [RadBits-1:0] rad_q;
	logic [RadBits+1:0] rem_q;
	logic [RootBits-1:0] root_q;
	logic [5:0] it_q;
	// divider
	logic dvd_lsb_q;
	logic [LenBits-1:0] dvs_q;
	logic [16:0] quo_q;
	logic [LenBits:0] drem_q;
	logic [4:0] dit_q;
	logic out_pend_q;
	logic out_free;

	// operand mux and shared multiplier
	logic signed [MisBits-1:0] m_op;
	logic [SqBits-1:0] m_sq;
	logic signed [DeltaBits-1:0] cax, cay, cbx, cby;
	logic signed [DeltaBits-1:0] ndax, nday, ndbx, ndby;
	logic [2*DeltaBits-1:0] sq_dax, sq_day, sq_dbx, sq_dby;
	logic [LenBits-1:0] ldiff;

	assign cax = $signed({1'b0, w_q.xa});
	assign cay = $signed({1'b0, w_q.ya});
	assign cbx = $signed({1'b0, w_q.xb});
	assign cby = $signed({1'b0, w_q.yb});
	assign ndax = cax - pax_q;
	assign nday = cay - pay_q;
	assign ndbx = cbx - pbx_q;
	assign ndby = cby - pby_q;

	always_comb begin
		case (state_q)
			ST_PX: m_op = MisBits'(cbx - cax);
			ST_PY: m_op = MisBits'(cby - cay);
			ST_VX: m_op = MisBits'(ndbx) - MisBits'(ndax);
			ST_VY: m_op = MisBits'(ndby) - MisBits'(nday);
			ST_AX: m_op = (MisBits'(ndbx) - MisBits'(dbx_q)) - (MisBits'(ndax) - MisBits'(dax_q));
			ST_AY: m_op = (MisBits'(ndby) - MisBits'(dby_q)) - (MisBits'(nday) - MisBits'(day_q));
			default: m_op = '0;
		endcase
	end
	assign m_sq = $unsigned(SqBits'(m_op) * SqBits'(m_op));

	// squared segment deltas for the root radicands
	assign sq_dax = $unsigned((2*DeltaBits)'(ndax) * (2*DeltaBits)'(ndax));
	assign sq_day = $unsigned((2*DeltaBits)'(nday) * (2*DeltaBits)'(nday));
	assign sq_dbx = $unsigned((2*DeltaBits)'(ndbx) * (2*DeltaBits)'(ndbx));
	assign sq_dby = $unsigned((2*DeltaBits)'(ndby) * (2*DeltaBits)'(ndby));

	// length difference feeding the divider
	assign ldiff = (la_q > lb_q) ? la_q - lb_q : lb_q - la_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_pend_q || out_ready;

	// sqrt and divide step logic
	logic [RadBits+1:0] trial;
	logic [LenBits:0] dsh;
	assign trial = {rem_q[RadBits-1:0], rad_q[RadBits-1 -: 2]} - (RadBits+2)'({root_q, 2'b01});
	assign dsh = {drem_q[LenBits-1:0], (dit_q == 5'd17) ? dvd_lsb_q : 1'b0};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) state_d = ST_PX;
			ST_PX: state_d = ST_PY;
			ST_PY: state_d = (n_q == '0) ? ST_ADDL : ST_VX;
			ST_VX: state_d = ST_VY;
			ST_VY: state_d = (n_q >= CntBits'(2)) ? ST_AX : ST_LA;
			ST_AX: state_d = ST_AY;
			ST_AY: state_d = ST_LA;
			ST_LA: state_d = ST_LB;
			ST_LB: state_d = ST_SQRT;
			ST_SQRT: if (it_q == '0) state_d = sel_b_q ? ST_ADDL : ST_LB;
			ST_ADDL: state_d = (w_q.last && n_q != '0) ? ST_DIV : (w_q.last ? ST_OUT : ST_IDLE);
			ST_DIV: if (dit_q == '0) state_d = ST_OUT;
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// control and accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_pend_q <= 1'b0;
			w_q <= '0;
			n_q <= '0;
			sel_b_q <= 1'b0;
			it_q <= '0;
			dit_q <= '0;
			rad_q <= '0; rem_q <= '0; root_q <= '0;
			dvd_lsb_q <= 1'b0; dvs_q <= '0; quo_q <= '0; drem_q <= '0;
			pax_q <= '0; pay_q <= '0; pbx_q <= '0; pby_q <= '0;
			dax_q <= '0; day_q <= '0; dbx_q <= '0; dby_q <= '0;
			fx_q <= '0; fy_q <= '0; ex_q <= '0; ey_q <= '0;
			posx_q <= '0; posy_q <= '0; velx_q <= '0; vely_q <= '0;
			accx_q <= '0; accy_q <= '0; la_q <= '0; lb_q <= '0;
			too_short <= 1'b0; length_ratio <= '0;
			pos_x_sum <= '0; pos_y_sum <= '0; vel_x_sum <= '0; vel_y_sum <= '0;
			acc_x_sum <= '0; acc_y_sum <= '0;
			first_x_sq <= '0; first_y_sq <= '0; end_x_sq <= '0; end_y_sq <= '0;
		end else begin
			// result register: loaded when free, cleared once taken
			if (state_q == ST_OUT && out_free) out_pend_q <= 1'b1;
			else if (out_valid && out_ready) out_pend_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					w_q <= in_word;
					sel_b_q <= 1'b0;
				end
				ST_PX: begin
					posx_q <= 30'(sat_add(64'(posx_q), 64'(m_sq), 30));
					ex_q <= m_sq;
					if (n_q == '0) fx_q <= m_sq;
				end
				ST_PY: begin
					posy_q <= 30'(sat_add(64'(posy_q), 64'(m_sq), 30));
					ey_q <= m_sq;
					if (n_q == '0) fy_q <= m_sq;
				end
				ST_VX: velx_q <= 32'(sat_add(64'(velx_q), 64'(m_sq), 32));
				ST_VY: vely_q <= 32'(sat_add(64'(vely_q), 64'(m_sq), 32));
				ST_AX: accx_q <= 34'(sat_add(64'(accx_q), 64'(m_sq), 34));
				ST_AY: accy_q <= 34'(sat_add(64'(accy_q), 64'(m_sq), 34));
				ST_LA: begin
					rad_q <= (RadBits'(sq_dax) + RadBits'(sq_day)) << (2 * FracBits);
					rem_q <= '0; root_q <= '0;
					it_q <= 6'(RootBits);
				end
				ST_LB: if (sel_b_q) begin
					rad_q <= (RadBits'(sq_dbx) + RadBits'(sq_dby)) << (2 * FracBits);
					rem_q <= '0; root_q <= '0;
					it_q <= 6'(RootBits);
				end
				ST_SQRT: if (it_q != '0) begin
					// one root bit per cycle
					rad_q <= rad_q << 2;
					it_q <= it_q - 6'd1;
					if (!trial[RadBits+1]) begin
						rem_q <= trial;
						root_q <= {root_q[RootBits-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[RadBits-1:0], rad_q[RadBits-1 -: 2]};
						root_q <= {root_q[RootBits-2:0], 1'b0};
					end
				end else if (!sel_b_q) begin
					la_q <= LenBits'(sat_add(64'(la_q), 64'(root_q), LenBits));
					sel_b_q <= 1'b1;
				end else begin
					lb_q <= LenBits'(sat_add(64'(lb_q), 64'(root_q), LenBits));
				end
				ST_ADDL: begin
					if (n_q != '0) begin
						dax_q <= ndax; day_q <= nday; dbx_q <= ndbx; dby_q <= ndby;
					end
					pax_q <= cax; pay_q <= cay; pbx_q <= cbx; pby_q <= cby;
					n_q <= (n_q + CntBits'(1) >= CntBits'(MaxPoints)) ? CntBits'(MaxPoints)
						: n_q + CntBits'(1);
					// remainder starts with diff>>1, its lsb enters on the first step
					dvd_lsb_q <= ldiff[0];
					dvs_q <= (la_q > lb_q) ? la_q : lb_q;
					drem_q <= {2'b00, ldiff[LenBits-1:1]};
					quo_q <= '0;
					dit_q <= 5'd17;
				end
				ST_DIV: if (dit_q != '0) begin
					// restoring divide of diff<<16, one bit per cycle
					dit_q <= dit_q - 5'd1;
					if (dsh >= {1'b0, dvs_q}) begin
						drem_q <= dsh - {1'b0, dvs_q};
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						drem_q <= dsh;
						quo_q <= {quo_q[15:0], 1'b0};
					end
				end
				ST_OUT: if (out_free) begin
					too_short <= (n_q < CntBits'(2));
					length_ratio <= (n_q < CntBits'(2) || dvs_q == '0) ? '0 : quo_q;
					pos_x_sum <= (n_q < CntBits'(2)) ? '0 : posx_q;
					pos_y_sum <= (n_q < CntBits'(2)) ? '0 : posy_q;
					vel_x_sum <= (n_q < CntBits'(2)) ? '0 : velx_q;
					vel_y_sum <= (n_q < CntBits'(2)) ? '0 : vely_q;
					acc_x_sum <= (n_q < CntBits'(2)) ? '0 : accx_q;
					acc_y_sum <= (n_q < CntBits'(2)) ? '0 : accy_q;
					first_x_sq <= (n_q < CntBits'(2)) ? '0 : 24'(sat_add(64'(fx_q), 64'd0, 24));
					first_y_sq <= (n_q < CntBits'(2)) ? '0 : 24'(sat_add(64'(fy_q), 64'd0, 24));
					end_x_sq <= (n_q < CntBits'(2)) ? '0 : 24'(sat_add(64'(ex_q), 64'd0, 24));
					end_y_sq <= (n_q < CntBits'(2)) ? '0 : 24'(sat_add(64'(ey_q), 64'd0, 24));
					n_q <= '0;
					pax_q <= '0; pay_q <= '0; pbx_q <= '0; pby_q <= '0;
					dax_q <= '0; day_q <= '0; dbx_q <= '0; dby_q <= '0;
					fx_q <= '0; fy_q <= '0;
					posx_q <= '0; posy_q <= '0; velx_q <= '0; vely_q <= '0;
					accx_q <= '0; accy_q <= '0; la_q <= '0; lb_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_pend_q;

`ifndef ASSERT_OFF
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("word taken while busy");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_valid)
		else $error("result not raised");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CntBits'(MaxPoints))
		else $error("point count overran");
`endif
endmodule

@@ src/trajectory_pair_feature_extractor_unit.sv @@
// top level: input queue in front of the feature sequencer
// Usage: one word per point pair (xa, ya, xb, yb, final_point) on the input
// channel, valid/ready handshake. The front queue holds two words, so the
// sender can run ahead while the back end works; a word is registered in the
// queue before the back end takes it. The back end squares the position
// differences of every point, from the second point on also the velocity
// differences and two bit-serial square roots of the segment lengths (17
// root bits plus an accumulate step each), and from the third point on the
// acceleration differences. A final word adds a bit-serial divide for the
// length ratio (skipped for a single point) and an output step. The result
// is held until taken; while the receiver stalls the back end carries on
// with the next trajectory until its own result is due, then waits, the
// queue fills and input ready drops. Reset (arst_n low) empties the queue,
// clears every sum and the point count, and drops output valid.
module trajectory_pair_feature_extractor_unit import tpfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] xa,
	input  logic [11:0] ya,
	input  logic [11:0] xb,
	input  logic [11:0] yb,
	input  logic        final_point,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [16:0] length_ratio,
	output logic [29:0] pos_x_sum,
	output logic [29:0] pos_y_sum,
	output logic [31:0] vel_x_sum,
	output logic [31:0] vel_y_sum,
	output logic [33:0] acc_x_sum,
	output logic [33:0] acc_y_sum,
	output logic [23:0] first_x_sq,
	output logic [23:0] first_y_sq,
	output logic [23:0] end_x_sq,
	output logic [23:0] end_y_sq,
	output logic        too_short
);
	tpfe_word_t in_word, q_word;
	logic q_valid, q_ready;

	assign in_word = '{xa: xa, ya: ya, xb: xb, yb: yb, last: final_point};

	// front queue
	tpfe_queue u_queue (
		.clk, .arst_n,
		.wr_valid(in_valid), .wr_ready(in_ready), .wr_word(in_word),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_word(q_word)
	);

	// back end
	tpfe_back u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
		.out_valid, .out_ready,
		.length_ratio, .pos_x_sum, .pos_y_sum, .vel_x_sum, .vel_y_sum,
		.acc_x_sum, .acc_y_sum, .first_x_sq, .first_y_sq, .end_x_sq, .end_y_sq,
		.too_short
	);
endmodule

@@ sim/tpfe_feature_checker.sv @@
// feature checker: watches both channels, predicts the result word and compares
module tpfe_feature_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [11:0] xa,
	input  logic [11:0] ya,
	input  logic [11:0] xb,
	input  logic [11:0] yb,
	input  logic        final_point,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [16:0] length_ratio,
	input  logic [29:0] pos_x_sum,
	input  logic [29:0] pos_y_sum,
	input  logic [31:0] vel_x_sum,
	input  logic [31:0] vel_y_sum,
	input  logic [33:0] acc_x_sum,
	input  logic [33:0] acc_y_sum,
	input  logic [23:0] first_x_sq,
	input  logic [23:0] first_y_sq,
	input  logic [23:0] end_x_sq,
	input  logic [23:0] end_y_sq,
	input  logic        too_short,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		longint unsigned ratio;
		longint unsigned pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
		longint unsigned fx, fy, ex, ey;
		bit              short_flag;
	} feature_word_t;

	feature_word_t feature_q[$];
	int errs;

	// trajectory state
	longint last_a[2], last_b[2], last_da[2], last_db[2];
	longint unsigned first_sq[2], pos_acc[2], vel_acc[2], acc_acc[2], path_len[2];
	int pairs_seen;

	assign mismatches = errs;

	function automatic longint unsigned sum_clip(longint unsigned a, longint unsigned b,
		int w);
		longint unsigned lim, s;
		lim = (64'd1 << w) - 1;
		s = a + b;
		return (s > lim) ? lim : s;
	endfunction

	// floor square root, one result bit per pass
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned clip24(longint unsigned v);
		return (v > 64'hFF_FFFF) ? 64'hFF_FFFF : v;
	endfunction

	task automatic clear_track();
		for (int k = 0; k < 2; k++) begin
			last_a[k] = 0; last_b[k] = 0; last_da[k] = 0; last_db[k] = 0;
			first_sq[k] = 0; pos_acc[k] = 0; vel_acc[k] = 0; acc_acc[k] = 0;
			path_len[k] = 0;
		end
		pairs_seen = 0;
	endtask

	// fold one point pair into the sums, queue a word on the final pair
	task automatic fold_pair();
		longint pa[2], pb[2], da[2], db[2], m;
		longint unsigned cur[2], la, lb, mx, df;
		feature_word_t w;
		int n;
		n = pairs_seen;
		pa[0] = xa; pa[1] = ya; pb[0] = xb; pb[1] = yb;
		for (int k = 0; k < 2; k++) begin
			cur[k] = (pb[k] - pa[k]) * (pb[k] - pa[k]);
			pos_acc[k] = sum_clip(pos_acc[k], cur[k], 30);
			if (n == 0) first_sq[k] = cur[k];
		end
		if (n >= 1) begin
			for (int k = 0; k < 2; k++) begin
				da[k] = pa[k] - last_a[k];
				db[k] = pb[k] - last_b[k];
				vel_acc[k] = sum_clip(vel_acc[k], (db[k] - da[k]) * (db[k] - da[k]), 32);
				if (n >= 2) begin
					m = (db[k] - last_db[k]) - (da[k] - last_da[k]);
					acc_acc[k] = sum_clip(acc_acc[k], m * m, 34);
				end
			end
			la = floor_root((da[0] * da[0] + da[1] * da[1]) << 8);
			lb = floor_root((db[0] * db[0] + db[1] * db[1]) << 8);
			path_len[0] = sum_clip(path_len[0], la, 23);
			path_len[1] = sum_clip(path_len[1], lb, 23);
			for (int k = 0; k < 2; k++) begin
				last_da[k] = da[k];
				last_db[k] = db[k];
			end
		end
		for (int k = 0; k < 2; k++) begin
			last_a[k] = pa[k];
			last_b[k] = pb[k];
		end
		pairs_seen = (n + 1 >= 64) ? 64 : n + 1;
		if (final_point) begin
			w = '{default: 0};
			if (pairs_seen < 2) begin
				w.short_flag = 1;
			end else begin
				mx = (path_len[0] > path_len[1]) ? path_len[0] : path_len[1];
				df = (path_len[0] > path_len[1]) ? path_len[0] - path_len[1]
					: path_len[1] - path_len[0];
				w.ratio = (mx != 0) ? ((df << 16) / mx) & 64'h1_FFFF : 0;
				w.pos_x = pos_acc[0]; w.pos_y = pos_acc[1];
				w.vel_x = vel_acc[0]; w.vel_y = vel_acc[1];
				w.acc_x = acc_acc[0]; w.acc_y = acc_acc[1];
				w.fx = clip24(first_sq[0]); w.fy = clip24(first_sq[1]);
				w.ex = clip24(cur[0]); w.ey = clip24(cur[1]);
			end
			feature_q.push_back(w);
			clear_track();
		end
	endtask

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			errs++;
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		feature_word_t w;
		if (!arst_n) begin
			clear_track();
			feature_q.delete();
			outstanding = 0;
		end else begin
			if (in_valid && in_ready) fold_pair();
			if (out_valid && out_ready) begin
				if (feature_q.size() == 0) begin
					errs++;
					$display("%0t: result word with nothing expected, got ratio %0d",
						$time, length_ratio);
				end else begin
					w = feature_q.pop_front();
					check_field("length_ratio", w.ratio, length_ratio);
					check_field("pos_x_sum", w.pos_x, pos_x_sum);
					check_field("pos_y_sum", w.pos_y, pos_y_sum);
					check_field("vel_x_sum", w.vel_x, vel_x_sum);
					check_field("vel_y_sum", w.vel_y, vel_y_sum);
					check_field("acc_x_sum", w.acc_x, acc_x_sum);
					check_field("acc_y_sum", w.acc_y, acc_y_sum);
					check_field("first_x_sq", w.fx, first_x_sq);
					check_field("first_y_sq", w.fy, first_y_sq);
					check_field("end_x_sq", w.ex, end_x_sq);
					check_field("end_y_sq", w.ey, end_y_sq);
					check_field("too_short", w.short_flag, too_short);
				end
			end
			outstanding = feature_q.size();
		end
	end

	initial errs = 0;

endmodule

@@ sim/trajectory_pair_feature_extractor_unit_test.sv @@
// stimulus and verdict for the trajectory pair feature extractor
module trajectory_pair_feature_extractor_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n;
	logic        in_valid, in_ready, final_point;
	logic [11:0] xa, ya, xb, yb;
	logic        out_valid, out_ready;
	logic [16:0] length_ratio;
	logic [29:0] pos_x_sum, pos_y_sum;
	logic [31:0] vel_x_sum, vel_y_sum;
	logic [33:0] acc_x_sum, acc_y_sum;
	logic [23:0] first_x_sq, first_y_sq, end_x_sq, end_y_sq;
	logic        too_short;
	int          mismatches, outstanding;
	int          pairs_sent, burst_left;

	trajectory_pair_feature_extractor_unit dut (.*);
	tpfe_feature_checker feature_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// generous overall limit
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	// offer one point pair and wait for it to be taken; bursts and gaps between
	task automatic offer_pair(logic [11:0] ax, ay, bx, by, logic fin);
		xa = ax; ya = ay; xb = bx; yb = by; final_point = fin;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		pairs_sent++;
		@(negedge clk);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			in_valid = 0;
			if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	function automatic logic [11:0] pick_coord(logic [11:0] near);
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			1, 2: return near + 12'($urandom_range(0, 15)) - 12'd8;
			default: return 12'($urandom);
		endcase
	endfunction

	// receiver: random short stalls, calm windows, one long hold-off
	initial begin
		int cyc, stall_left;
		out_ready = 0;
		cyc = 0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= 3000 && cyc < 3800) begin
				out_ready = 0;
			end else if (stall_left > 0) begin
				out_ready = 0;
				stall_left--;
			end else begin
				out_ready = 1;
				if ((cyc / 4000) % 2 == 0 && $urandom_range(0, 3) == 0)
					stall_left = $urandom_range(1, 40);
			end
		end
	end

	initial begin
		int len, kind;
		logic [11:0] ax, ay, bx, by;
		in_valid = 0; final_point = 0;
		xa = 0; ya = 0; xb = 0; yb = 0;
		pairs_sent = 0;
		burst_left = 4;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: single point, field extremes, equal and one-sided lengths
		offer_pair(12'hFFF, 12'h000, 12'h000, 12'hFFF, 1);
		offer_pair(12'h000, 12'h000, 12'h000, 12'h000, 1);
		offer_pair(12'h000, 12'hFFF, 12'hFFF, 12'h000, 0);
		offer_pair(12'hFFF, 12'h000, 12'h000, 12'hFFF, 1);
		offer_pair(12'h000, 12'h000, 12'hFFF, 12'hFFF, 0);
		offer_pair(12'hFFF, 12'hFFF, 12'h000, 12'h000, 0);
		offer_pair(12'h000, 12'h000, 12'hFFF, 12'hFFF, 1);
		offer_pair(12'h123, 12'h456, 12'h123, 12'h456, 0);
		offer_pair(12'h123, 12'h456, 12'h123, 12'h456, 0);
		offer_pair(12'h123, 12'h456, 12'h123, 12'h456, 1);
		offer_pair(12'h800, 12'h800, 12'h100, 12'h100, 0);
		offer_pair(12'h800, 12'h800, 12'h900, 12'hA00, 0);
		offer_pair(12'h800, 12'h800, 12'hFFF, 12'h000, 1);
		offer_pair(12'h555, 12'hAAA, 12'hAAA, 12'h555, 0);
		offer_pair(12'hAAA, 12'h555, 12'h555, 12'hAAA, 1);

		// random trajectories, a few long ones that saturate every sum
		for (int t = 0; pairs_sent < 1550; t++) begin
			kind = $urandom_range(0, 39);
			if (t == 45) begin
				// let the block drain fully before carrying on
				in_valid = 0;
				while (outstanding != 0) @(negedge clk);
			end
			if (t == 10 || t == 120 || kind == 0) begin
				len = (kind == 0) ? $urandom_range(65, 100) : 110;
				for (int p = 0; p < len; p++) begin
					if (kind == 0) begin
						ax = 12'($urandom); ay = 12'($urandom);
						bx = 12'($urandom); by = 12'($urandom);
					end else begin
						ax = p[0] ? 12'hFFF : 12'h000;
						ay = ax; bx = ~ax; by = ~ax;
					end
					offer_pair(ax, ay, bx, by, p == len - 1);
				end
			end else begin
				len = (kind < 3) ? 1 : $urandom_range(2, 14);
				ax = 12'($urandom); ay = 12'($urandom);
				bx = 12'($urandom); by = 12'($urandom);
				for (int p = 0; p < len; p++) begin
					ax = pick_coord(ax); ay = pick_coord(ay);
					bx = pick_coord(bx); by = pick_coord(by);
					offer_pair(ax, ay, bx, by, p == len - 1);
				end
			end
		end
		in_valid = 0;

		while (outstanding != 0) @(negedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
